@@ rtl/wts_pkg.sv @@
// Package for the word token splitter: token descriptor type, character codes
// and the byte classification helpers.
// Used by every module of the block; depends on nothing.
package wts_pkg;

	// Token length field; holds lengths up to 63, above the TOKEN_LEN-1 of the largest stored token.
	localparam int unsigned LEN_W   = 6;
	localparam int unsigned IDX_W   = 6;
	localparam int unsigned TOTAL_W = 7;
	localparam int unsigned POS_W   = 5;

	// Descriptor queue between the front and the back.
	localparam int unsigned DQ_DEPTH = 4;
	localparam int unsigned DQ_AW    = 2;

	// Character codes.
	localparam logic [7:0] CH_END  = 8'h00;
	localparam logic [7:0] CH_APOS = 8'h27;
	localparam logic [7:0] CH_A    = 8'h61;
	localparam logic [7:0] CH_I    = 8'h69;

	// One finished token waiting to be sent, or an end-of-text report when len is zero.
	typedef struct packed {
		logic               done;
		logic [LEN_W-1:0]   len;
		logic [IDX_W-1:0]   idx;
		logic [TOTAL_W-1:0] total;
	} desc_t;

	// Whitespace and punctuation, apostrophe excluded, split tokens.
	function automatic logic splits_token(input logic [7:0] b);
		logic ws;
		logic punct;
		ws    = (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
		punct = (b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
			(b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
		return ws || (punct && (b != CH_APOS));
	endfunction

	// Maps upper-case ASCII letters to lower case; every other byte passes.
	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return (b >= 8'd65 && b <= 8'd90) ? (b + 8'd32) : b;
	endfunction

endpackage

@@ rtl/word_token_splitter.sv @@
// Word token splitter top level: front end, descriptor queue and back end.
// Depends on wts_pkg, wts_front, wts_desc_fifo and wts_back.
//
// Usage: text bytes enter on in_valid/in_ready/in_byte, one byte per beat;
// byte 0 ends a text. Each kept token leaves on the output channel as one
// beat per character (has_char=1) with its position, token index and a
// token_last flag; the end byte sets text_done on the last beat it causes,
// or sends one beat with has_char=0 when no token is flushed.
// A token's closing byte pushes its descriptor into the queue; the back end
// loads it and passes each character through the read stage and the output
// register. Throughput: one text byte per cycle on the input; the back end
// sends one character per cycle while out_ready allows, plus a descriptor
// load that a token's closing byte covers. The input stalls only when the
// character ring (a power of two, at least 2*(TOKEN_LEN-1) bytes) or the 4-entry queue is full.
// When the receiver holds out_ready low, the output register and the read
// stage hold, the back end stops, and the queue and ring then fill.
// Reset (arst_n low) empties the ring, queue and pipeline and clears the
// token and emitted counts; the block is ready on the first cycle after.
module word_token_splitter #(
	parameter int unsigned TOKEN_LEN   = 32,
	parameter int unsigned TOKEN_LIMIT = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   in_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         has_char,
	output logic [7:0]                   out_char,
	output logic [wts_pkg::POS_W-1:0]    char_pos,
	output logic [wts_pkg::IDX_W-1:0]    token_index,
	output logic                         token_last,
	output logic                         text_done,
	output logic [wts_pkg::TOTAL_W-1:0]  token_total
);

	localparam int unsigned STORE_DEPTH = TOKEN_LEN - 1;
	localparam int unsigned RING_AW     = $clog2(2 * STORE_DEPTH);
	localparam int unsigned PTR_W       = RING_AW + 1;
	localparam int unsigned RING        = 1 << RING_AW;

	logic               wr_en;
	logic [RING_AW-1:0] wr_addr;
	logic [7:0]         wr_data;
	logic [PTR_W-1:0]   wr_ptr;
	logic [PTR_W-1:0]   rd_ptr;
	logic               dq_push;
	logic               dq_full;
	logic               dq_valid;
	logic               dq_pop;
	wts_pkg::desc_t     dq_din;
	wts_pkg::desc_t     dq_dout;

	// Byte intake and classification.
	wts_front #(
		.TOKEN_LEN   (TOKEN_LEN),
		.TOKEN_LIMIT (TOKEN_LIMIT),
		.RING_AW     (RING_AW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.wr_ptr   (wr_ptr),
		.rd_ptr   (rd_ptr),
		.dq_push  (dq_push),
		.dq_desc  (dq_din),
		.dq_full  (dq_full)
	);

	// Token descriptor queue.
	wts_desc_fifo u_dq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (dq_push),
		.din    (dq_din),
		.full   (dq_full),
		.valid  (dq_valid),
		.pop    (dq_pop),
		.dout   (dq_dout)
	);

	// Character ring and result output.
	wts_back #(
		.RING_AW (RING_AW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_ptr      (rd_ptr),
		.dq_valid    (dq_valid),
		.dq_desc     (dq_dout),
		.dq_pop      (dq_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.has_char    (has_char),
		.out_char    (out_char),
		.char_pos    (char_pos),
		.token_index (token_index),
		.token_last  (token_last),
		.text_done   (text_done),
		.token_total (token_total)
	);

`ifndef ASSERT_OFF
	// The ring never holds more characters than it has entries.
	a_ring_bound: assert property (@(posedge clk) disable iff (!arst_n)
		PTR_W'(wr_ptr - rd_ptr) <= PTR_W'(RING))
		else $error("character ring overrun");

	// The front never pushes a descriptor into a full queue.
	a_dq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		dq_push |-> !dq_full)
		else $error("descriptor queue overflow");

	// Only character beats can close a token.
	a_last_has_char: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && token_last) |-> has_char)
		else $error("token_last on a beat without a character");

	// A beat without a character is only ever the end-of-text report.
	a_empty_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_char) |-> text_done)
		else $error("empty beat without text_done");
`endif

endmodule

@@ rtl/wts_desc_fifo.sv @@
// Short queue of token descriptors between the front and the back.
// Depends on wts_pkg for desc_t and the queue depth.
module wts_desc_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  wts_pkg::desc_t din,
	output logic           full,
	output logic           valid,
	input  logic           pop,
	output wts_pkg::desc_t dout
);

	wts_pkg::desc_t                 mem [wts_pkg::DQ_DEPTH];
	logic [wts_pkg::DQ_AW-1:0]      wp_q;
	logic [wts_pkg::DQ_AW-1:0]      rp_q;
	logic [wts_pkg::DQ_AW:0]        cnt_q;

	// Occupancy flags and head of queue.
	assign full  = (cnt_q == (wts_pkg::DQ_AW+1)'(wts_pkg::DQ_DEPTH));
	assign valid = (cnt_q != '0);
	assign dout  = mem[rp_q];

	// Pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) mem[wp_q] <= din;
	end

endmodule

@@ rtl/wts_front.sv @@
// Front end: accepts text bytes, classifies them, writes token characters into
// the character ring and queues a descriptor per kept token and per text end. Uses wts_pkg.
module wts_front #(
	parameter int unsigned TOKEN_LEN   = 32,
	parameter int unsigned TOKEN_LIMIT = 64,
	parameter int unsigned RING_AW     = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_byte,
	output logic                 wr_en,
	output logic [RING_AW-1:0]   wr_addr,
	output logic [7:0]           wr_data,
	output logic [RING_AW:0]     wr_ptr,
	input  logic [RING_AW:0]     rd_ptr,
	output logic                 dq_push,
	output wts_pkg::desc_t       dq_desc,
	input  logic                 dq_full
);

	localparam int unsigned STORE_DEPTH = TOKEN_LEN - 1;
	localparam int unsigned CNT_W       = $clog2(TOKEN_LIMIT + 1);
	localparam int unsigned PTR_W       = RING_AW + 1;
	localparam int unsigned RING        = 1 << RING_AW;

	logic [wts_pkg::LEN_W-1:0] cnt_q;
	logic [7:0]                first_q;
	logic [CNT_W-1:0]          emitted_q;
	logic                      full_q;
	logic [PTR_W-1:0]          wr_ptr_q;
	logic [PTR_W-1:0]          tok_start_q;

	logic             is_end;
	logic             is_bnd;
	logic             kept;
	logic             char_wr;
	logic             flush;
	logic             push_req;
	logic             ring_full;
	logic             acc;
	logic [CNT_W-1:0] emitted_inc;

	// Classify the byte on the input and decide what it does.
	always_comb begin
		is_end      = (in_byte == wts_pkg::CH_END);
		is_bnd      = wts_pkg::splits_token(in_byte);
		kept        = !full_q && ((cnt_q == wts_pkg::LEN_W'(1)) ?
			((first_q == wts_pkg::CH_A) || (first_q == wts_pkg::CH_I)) : (cnt_q != '0));
		char_wr     = !is_end && !full_q && !is_bnd &&
			(cnt_q < wts_pkg::LEN_W'(STORE_DEPTH));
		flush       = is_end || (is_bnd && !full_q);
		push_req    = is_end || (flush && kept);
		ring_full   = (PTR_W'(wr_ptr_q - rd_ptr) == PTR_W'(RING));
		emitted_inc = emitted_q + CNT_W'(1);
	end

	// Stall only when this byte needs ring space or a queue slot that is taken.
	assign in_ready = !(char_wr && ring_full) && !(push_req && dq_full);
	assign acc      = in_valid && in_ready;

	assign wr_en   = acc && char_wr;
	assign wr_addr = wr_ptr_q[RING_AW-1:0];
	assign wr_data = wts_pkg::to_lower(in_byte);
	assign wr_ptr  = wr_ptr_q;

	// Descriptor for a kept token, or the bare end-of-text report.
	always_comb begin
		dq_push      = acc && push_req;
		dq_desc.done = is_end;
		if (kept) begin
			dq_desc.len   = cnt_q;
			dq_desc.idx   = wts_pkg::IDX_W'(emitted_q);
			dq_desc.total = wts_pkg::TOTAL_W'(emitted_inc);
		end else begin
			dq_desc.len   = '0;
			dq_desc.idx   = '0;
			dq_desc.total = wts_pkg::TOTAL_W'(emitted_q);
		end
	end

	// Token collection state; a discarded token rewinds the ring write pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			emitted_q   <= '0;
			full_q      <= 1'b0;
			wr_ptr_q    <= '0;
			tok_start_q <= '0;
		end else if (acc) begin
			if (char_wr) begin
				cnt_q    <= cnt_q + 1'b1;
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end else if (flush) begin
				cnt_q <= '0;
				if (kept) begin
					tok_start_q <= wr_ptr_q;
					emitted_q   <= emitted_inc;
					full_q      <= (emitted_q == CNT_W'(TOKEN_LIMIT - 1));
				end else begin
					wr_ptr_q <= tok_start_q;
				end
				if (is_end) begin
					emitted_q <= '0;
					full_q    <= 1'b0;
				end
			end
		end
	end

	// First character of the token, for the single-letter filter.
	always_ff @(posedge clk) begin
		if (acc && char_wr && (cnt_q == '0)) first_q <= wr_data;
	end

endmodule

@@ rtl/wts_back.sv @@
// Back end: holds the character ring and turns each token descriptor into one
// beat per character, or one bare beat if empty. Uses wts_pkg for desc_t and field widths.
module wts_back #(
	parameter int unsigned RING_AW = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [RING_AW-1:0]           wr_addr,
	input  logic [7:0]                   wr_data,
	output logic [RING_AW:0]             rd_ptr,
	input  logic                         dq_valid,
	input  wts_pkg::desc_t               dq_desc,
	output logic                         dq_pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         has_char,
	output logic [7:0]                   out_char,
	output logic [wts_pkg::POS_W-1:0]    char_pos,
	output logic [wts_pkg::IDX_W-1:0]    token_index,
	output logic                         token_last,
	output logic                         text_done,
	output logic [wts_pkg::TOTAL_W-1:0]  token_total
);

	localparam int unsigned RING = 1 << RING_AW;

	logic [7:0] ring [RING];

	logic                        act_q;
	wts_pkg::desc_t              cur_q;
	logic [wts_pkg::LEN_W-1:0]   pos_q;
	logic [RING_AW:0]            rd_ptr_q;

	logic                        v_s1;
	logic                        has_s1;
	logic [7:0]                  char_s1;
	logic [wts_pkg::LEN_W-1:0]   pos_s1;
	logic [wts_pkg::IDX_W-1:0]   idx_s1;
	logic                        last_s1;
	logic                        done_s1;
	logic [wts_pkg::TOTAL_W-1:0] total_s1;

	logic out_valid_q;
	logic s1_adv;
	logic s1_free;
	logic issue;
	logic is_empty;
	logic last_now;
	logic issue_char;

	// Pipeline control: read stage feeds the output register.
	always_comb begin
		s1_adv     = v_s1 && (!out_valid_q || out_ready);
		s1_free    = !v_s1 || s1_adv;
		issue      = act_q && s1_free;
		is_empty   = (cur_q.len == '0);
		last_now   = is_empty || (pos_q == (cur_q.len - wts_pkg::LEN_W'(1)));
		issue_char = issue && !is_empty;
		dq_pop     = !act_q && dq_valid;
	end

	assign rd_ptr = rd_ptr_q;

	// Descriptor walk and ring read pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			pos_q    <= '0;
			rd_ptr_q <= '0;
			v_s1     <= 1'b0;
		end else begin
			if (dq_pop) begin
				act_q <= 1'b1;
				pos_q <= '0;
			end else if (issue) begin
				if (last_now) act_q <= 1'b0;
				else          pos_q <= pos_q + 1'b1;
			end
			if (issue_char) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (issue)       v_s1 <= 1'b1;
			else if (s1_adv) v_s1 <= 1'b0;
		end
	end

	// Current descriptor.
	always_ff @(posedge clk) begin
		if (dq_pop) cur_q <= dq_desc;
	end

	// Character ring: written by the front, read one character per beat.
	always_ff @(posedge clk) begin
		if (wr_en) ring[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (issue_char) char_s1 <= ring[rd_ptr_q[RING_AW-1:0]];
	end

	// Read stage result fields.
	always_ff @(posedge clk) begin
		if (issue) begin
			has_s1   <= !is_empty;
			pos_s1   <= pos_q;
			idx_s1   <= cur_q.idx;
			last_s1  <= !is_empty && last_now;
			done_s1  <= cur_q.done && last_now;
			total_s1 <= cur_q.total;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			has_char    <= has_s1;
			out_char    <= has_s1 ? char_s1 : 8'h00;
			char_pos    <= wts_pkg::POS_W'(pos_s1);
			token_index <= idx_s1;
			token_last  <= last_s1;
			text_done   <= done_s1;
			token_total <= total_s1;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ sim/tb.sv @@
// Self-checking bench for word_token_splitter: streams text bytes, predicts
// every output beat in the bench itself and compares each beat on arrival.
// Depends on wts_pkg and the word_token_splitter RTL.
module tb;

	localparam int TOKEN_LEN   = 32;
	localparam int TOKEN_LIMIT = 64;
	localparam int STORE_DEPTH = TOKEN_LEN - 1;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_AFTER  = 60;
	localparam int HOLD_CYCLES = 300;

	// One beat on the output channel.
	typedef struct packed {
		logic                        has_char;
		logic [7:0]                  ch;
		logic [wts_pkg::POS_W-1:0]   pos;
		logic [wts_pkg::IDX_W-1:0]   idx;
		logic                        last;
		logic                        done;
		logic [wts_pkg::TOTAL_W-1:0] total;
	} char_beat_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic [7:0]                   in_byte = 8'h00;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic                         has_char;
	logic [7:0]                   out_char;
	logic [wts_pkg::POS_W-1:0]    char_pos;
	logic [wts_pkg::IDX_W-1:0]    token_index;
	logic                         token_last;
	logic                         text_done;
	logic [wts_pkg::TOTAL_W-1:0]  token_total;

	// Text bytes still to be offered, and beats still to arrive.
	logic [7:0] text_q[$];
	char_beat_t char_beats[$];

	// Predicted splitter state.
	logic [7:0] char_buf [STORE_DEPTH];
	int         held_len = 0;
	int         tok_count = 0;
	bit         table_full = 1'b0;

	int mismatches = 0;
	int cycles = 0;
	int in_count = 0;
	bit in_fire = 1'b0;

	// Sender burst state.
	int burst_left = 0;
	int gap_left = 0;

	// Receiver stall state.
	logic [15:0] rx_pattern = 16'hFFFF;
	logic [3:0]  rx_phase = 4'd0;
	int          hold_left = 0;
	bit          hold_used = 1'b0;

	// Opening text: empty text, kept and filtered single letters, a boundary
	// with nothing held, extreme and non-letter token bytes, an end byte
	// after a filtered letter and an end byte that flushes a token.
	logic [7:0] opening [22] = '{
		8'h00,
		8'h41, 8'h20,
		8'h78, 8'h2C,
		8'h09,
		8'h49, 8'h0D,
		8'hFF, 8'h80, 8'h27, 8'h01, 8'h7F, 8'h5A, 8'h7E,
		8'h30, 8'h21,
		8'h71, 8'h00,
		8'h62, 8'h79, 8'h00
	};

	word_token_splitter #(
		.TOKEN_LEN  (TOKEN_LEN),
		.TOKEN_LIMIT(TOKEN_LIMIT)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.has_char   (has_char),
		.out_char   (out_char),
		.char_pos   (char_pos),
		.token_index(token_index),
		.token_last (token_last),
		.text_done  (text_done),
		.token_total(token_total)
	);

	// Clock with period 2.
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Whitespace and punctuation other than the apostrophe split words.
	function automatic bit is_gap_byte(input logic [7:0] b);
		if (b == 8'd32 || (b >= 8'd9 && b <= 8'd13)) begin
			return 1'b1;
		end
		if (b == wts_pkg::CH_APOS) begin
			return 1'b0;
		end
		return (b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
			(b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
	endfunction

	// Emits the held word when it survives the single-letter filter.
	task automatic flush_word(input bit at_end, output int produced);
		char_beat_t r;
		bit         keep;
		produced = 0;
		if (held_len == 1) begin
			keep = (char_buf[0] == wts_pkg::CH_A) || (char_buf[0] == wts_pkg::CH_I);
		end else begin
			keep = (held_len > 0);
		end
		if (!table_full && keep) begin
			for (int i = 0; i < held_len; i++) begin
				r = '0;
				r.has_char = 1'b1;
				r.ch = char_buf[i];
				r.pos = wts_pkg::POS_W'(i);
				r.idx = wts_pkg::IDX_W'(tok_count);
				r.last = (i == held_len - 1);
				r.done = at_end && (i == held_len - 1);
				r.total = wts_pkg::TOTAL_W'(tok_count + 1);
				char_beats.push_back(r);
				produced++;
			end
			tok_count++;
			if (tok_count >= TOKEN_LIMIT) begin
				table_full = 1'b1;
			end
		end
		held_len = 0;
	endtask

	// Advances the predicted state by one accepted text byte.
	task automatic split_byte(input logic [7:0] b);
		int         produced;
		char_beat_t r;
		if (b == wts_pkg::CH_END) begin
			flush_word(1'b1, produced);
			if (produced == 0) begin
				r = '0;
				r.done = 1'b1;
				r.total = wts_pkg::TOTAL_W'(tok_count);
				char_beats.push_back(r);
			end
			held_len = 0;
			tok_count = 0;
			table_full = 1'b0;
		end else if (!table_full) begin
			if (is_gap_byte(b)) begin
				flush_word(1'b0, produced);
			end else if (held_len < STORE_DEPTH) begin
				char_buf[held_len] = (b >= 8'd65 && b <= 8'd90) ? b + 8'd32 : b;
				held_len++;
			end
		end
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	// Random token byte: mostly letters, with digits, apostrophes, control
	// bytes and bytes with the top bit set.
	function automatic logic [7:0] word_byte();
		logic [7:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: v = 8'($urandom_range(97, 122));
			5, 6: v = 8'($urandom_range(65, 90));
			7: v = 8'($urandom_range(48, 57));
			8: v = wts_pkg::CH_APOS;
			default: begin
				case ($urandom_range(0, 3))
					0: v = 8'($urandom_range(1, 8));
					1: v = 8'($urandom_range(14, 31));
					2: v = 8'd127;
					default: v = 8'($urandom_range(128, 255));
				endcase
			end
		endcase
		return v;
	endfunction

	// Random boundary byte.
	function automatic logic [7:0] gap_byte();
		logic [7:0] v;
		case ($urandom_range(0, 5))
			0: v = 8'd32;
			1: v = 8'($urandom_range(9, 13));
			2: begin
				v = 8'($urandom_range(33, 47));
				if (v == wts_pkg::CH_APOS) begin
					v = 8'd46;
				end
			end
			3: v = 8'($urandom_range(58, 64));
			4: v = 8'($urandom_range(91, 96));
			default: v = 8'($urandom_range(123, 126));
		endcase
		return v;
	endfunction

	// Queues one text of random words, closed by the end byte.
	task automatic add_text(input int words, input bit short_words);
		int len;
		int pick;
		for (int w = 0; w < words; w++) begin
			if (short_words) begin
				len = $urandom_range(2, 3);
			end else begin
				pick = $urandom_range(0, 19);
				if (pick < 5) begin
					len = 1;
				end else if (pick < 18) begin
					len = $urandom_range(2, 8);
				end else begin
					len = $urandom_range(25, 40);
				end
			end
			for (int c = 0; c < len; c++) begin
				text_q.push_back(word_byte());
			end
			// Occasional stray byte of any non-zero value.
			if ($urandom_range(0, 9) == 0) begin
				text_q.push_back(8'($urandom_range(1, 255)));
			end
			if (w < words - 1 || $urandom_range(0, 1) == 1) begin
				repeat ($urandom_range(1, 2)) text_q.push_back(gap_byte());
			end
		end
		text_q.push_back(wts_pkg::CH_END);
	endtask

	task automatic wait_drained();
		while (text_q.size() > 0 || in_valid || char_beats.size() > 0) begin
			@(posedge clk);
		end
	endtask

	// Sender: offers queued bytes in bursts separated by random gaps.
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_fire)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (text_q.size() > 0) begin
				in_byte <= text_q.pop_front();
				in_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: one long hold-off once the text is flowing, otherwise a
	// stall pattern drawn anew each time the 4-bit phase counter wraps.
	always @(negedge clk) begin
		if (!hold_used && in_count >= HOLD_AFTER) begin
			hold_used = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (rx_phase == 4'd0) begin
				case ($urandom_range(0, 3))
					0: rx_pattern = 16'hFFFF;
					1: rx_pattern = 16'($urandom);
					2: rx_pattern = 16'($urandom | $urandom);
					default: rx_pattern = 16'($urandom & $urandom);
				endcase
			end
			out_ready <= rx_pattern[rx_phase];
			rx_phase = rx_phase + 4'd1;
		end
	end

	// Monitor: predicts on each input beat and checks each output beat.
	always @(posedge clk) begin
		char_beat_t want;
		in_fire = arst_n && in_valid && in_ready;
		if (in_fire) begin
			split_byte(in_byte);
			in_count++;
		end
		if (arst_n && out_valid && out_ready) begin
			if (char_beats.size() == 0) begin
				$error("output beat with nothing expected: has_char %0d out_char %0d",
					has_char, out_char);
				mismatches++;
			end else begin
				want = char_beats.pop_front();
				check_field("has_char", 32'(want.has_char), 32'(has_char));
				check_field("out_char", 32'(want.ch), 32'(out_char));
				check_field("char_pos", 32'(want.pos), 32'(char_pos));
				check_field("token_index", 32'(want.idx), 32'(token_index));
				check_field("token_last", 32'(want.last), 32'(token_last));
				check_field("text_done", 32'(want.done), 32'(text_done));
				check_field("token_total", 32'(want.total), 32'(token_total));
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Stimulus: opening text, a full drain, then random texts with one
	// text long enough to fill the token table.
	initial begin
		int texts;
		int queued;
		int q_was;
		texts = 0;
		queued = 0;
		foreach (opening[i]) begin
			text_q.push_back(opening[i]);
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait_drained();
		while (queued < 300) begin
			q_was = text_q.size();
			if (texts == 1) begin
				add_text(TOKEN_LIMIT + 6, 1'b1);
			end else begin
				add_text($urandom_range(0, 12), 1'b0);
			end
			queued += text_q.size() - q_was;
			texts++;
			if (texts == 4) begin
				wait_drained();
			end
		end
		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
